// ===== sv/rsct_pkg.sv =====
// ---------------------------------------------------------------------------
// rsct_pkg
// Shared types, codes and constants of the radio and sleep countdown timers.
// ---------------------------------------------------------------------------
package rsct_pkg;

    // command codes
    typedef enum logic [3:0] {
        CMD_TICK         = 4'd0,
        CMD_PLAN         = 4'd1,
        CMD_STOP         = 4'd2,
        CMD_START        = 4'd3,
        CMD_CANCEL_STOP  = 4'd4,
        CMD_CANCEL_START = 4'd5,
        CMD_CANCEL_PLAN  = 4'd6,
        CMD_SLEEP        = 4'd7,
        CMD_CANCEL_SLEEP = 4'd8,
        CMD_SLEEP_NOW    = 4'd9,
        CMD_QUERY        = 4'd10
    } t_cmd;

    // result status codes
    typedef enum logic [3:0] {
        ST_APPLIED    = 4'd0,
        ST_CANCELLED  = 4'd1,
        ST_INVALID    = 4'd2,
        ST_EMPTY      = 4'd3,
        ST_ORDER      = 4'd4,
        ST_SHUTDOWN   = 4'd5,
        ST_SLEEP_CONF = 4'd6,
        ST_RADIO_CONF = 4'd7,
        ST_WAKE_NEED  = 4'd8
    } t_status;

    // plan kinds
    typedef enum logic [1:0] {
        PK_NONE  = 2'd0,
        PK_RADIO = 2'd1,
        PK_SLEEP = 2'd2
    } t_plan;

    // shutdown sequence phases
    typedef enum logic [2:0] {
        PH_NONE   = 3'd0,
        PH_WAIT   = 3'd1,
        PH_FLUSH  = 3'd2,
        PH_DSPOFF = 3'd3,
        PH_SETTLE = 3'd4,
        PH_ENTER  = 3'd5,
        PH_HALT   = 3'd6
    } t_phase;

    // configuration register indexes
    localparam logic [2:0] CFG_MAX_MIN   = 3'd0;
    localparam logic [2:0] CFG_WAKE_EN   = 3'd1;
    localparam logic [2:0] CFG_WAKE_MIN  = 3'd2;
    localparam logic [2:0] CFG_STOP_WAIT = 3'd3;
    localparam logic [2:0] CFG_SETTLE    = 3'd4;

    localparam int MS_W  = 28;   // countdown length in ms fits 4095 minutes
    localparam int SEC_W = 18;

    localparam logic [MS_W-1:0] MS_PER_MIN = 28'd60000;
    localparam logic [MS_W-1:0] ROUND_UP   = 28'd999;

    // ceil(2^38 / 1000), exact quotient for dividends below 2^28
    localparam logic [28:0] RECIP_1000 = 29'd274877907;
    localparam int          RECIP_SH   = 38;

    typedef struct packed {
        logic [11:0] max_minutes;
        logic        wake_en;
        logic [11:0] preset_min;
        logic [15:0] stop_wait_ms;
        logic [15:0] settle_ms;
    } t_cfg;

    typedef struct packed {
        t_cmd            command;
        logic [31:0]     now_ms;
        logic [15:0]     first_minutes;
        logic [15:0]     second_minutes;
        logic            wake_from_preset;
        logic            player_stopped;
        logic [MS_W-1:0] first_ms;
        logic [MS_W-1:0] second_ms;
    } t_item;

    typedef struct packed {
        t_status         status;
        t_plan           plan_kind;
        logic [MS_W-1:0] stop_rem_ms;
        logic [MS_W-1:0] start_rem_ms;
        logic [MS_W-1:0] sleep_rem_ms;
        logic [11:0]     wake_after;
        logic            busy;
        logic            p_stop;
        logic            p_play;
        logic            p_resume;
        logic            p_dsp_off;
        logic            p_enter;
    } t_res;

endpackage

// ===== sv/rsct_div1000.sv =====
// ---------------------------------------------------------------------------
// rsct_div1000
// Remaining milliseconds to whole seconds, rounded up, by reciprocal multiply.
// ---------------------------------------------------------------------------
module rsct_div1000
    import rsct_pkg::*;
(
    input  logic [MS_W-1:0]  i_ms,
    output logic [SEC_W-1:0] o_sec
);

    logic [MS_W-1:0]      w_x;
    logic [MS_W+28:0]     w_prod;

    // ceil(ms / 1000) = floor((ms + 999) / 1000)
    assign w_x    = i_ms + ROUND_UP;
    assign w_prod = {29'd0, w_x} * {28'd0, RECIP_1000};
    assign o_sec  = w_prod[RECIP_SH+SEC_W-1:RECIP_SH];

endmodule

// ===== sv/rsct_update.sv =====
// ---------------------------------------------------------------------------
// rsct_update
// Timer and shutdown state with its next-state logic for one command word.
// ---------------------------------------------------------------------------
module rsct_update
    import rsct_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_advance,
    input  t_item i_item,
    input  t_cfg  i_cfg,
    output t_res  o_res
);

    logic            r_stop_act, n_stop_act;
    logic [31:0]     r_stop_beg, n_stop_beg;
    logic [MS_W-1:0] r_stop_dur, n_stop_dur;
    logic [31:0]     r_stop_dl,  n_stop_dl;
    logic            r_start_act, n_start_act;
    logic [31:0]     r_start_beg, n_start_beg;
    logic [MS_W-1:0] r_start_dur, n_start_dur;
    logic [31:0]     r_start_dl,  n_start_dl;
    logic            r_sleep_act, n_sleep_act;
    logic [31:0]     r_sleep_beg, n_sleep_beg;
    logic [MS_W-1:0] r_sleep_dur, n_sleep_dur;
    logic [11:0]     r_planned, n_planned;
    logic            r_req, n_req;
    logic [11:0]     r_req_wake, n_req_wake;
    logic            r_sd_on, n_sd_on;
    t_phase          r_phase, n_phase;
    logic [31:0]     r_wait_dl, n_wait_dl;
    logic [31:0]     r_settle_beg, n_settle_beg;
    logic            r_resume, n_resume;

    function automatic logic later_than(input logic [31:0] a, input logic [31:0] b);
        logic [31:0] d;
        d = a - b;
        return (d != 32'd0) && !d[31];
    endfunction

    function automatic logic [MS_W-1:0] rem_ms(input logic act, input logic [31:0] beg,
                                               input logic [MS_W-1:0] dur,
                                               input logic [31:0] now);
        logic [31:0] el;
        el = now - beg;
        if (act && el < {4'd0, dur}) begin
            return dur - el[MS_W-1:0];
        end
        return '0;
    endfunction

    // next state and result of one word
    always_comb begin
        logic [31:0]     now;
        logic [15:0]     m1;
        logic [15:0]     m2;
        logic            stopped;
        t_plan           pk;
        t_status         st;
        t_status         ws;
        logic [11:0]     wake;
        logic [11:0]     pm;
        logic            se, te, de, sl;
        logic            do_accept;
        logic [11:0]     acc_w;
        logic [31:0]     dl1;
        logic [31:0]     dl2;
        logic [31:0]     el_set;
        logic [31:0]     el_wait;

        now     = i_item.now_ms;
        m1      = i_item.first_minutes;
        m2      = i_item.second_minutes;
        stopped = i_item.player_stopped;
        dl1     = now + {4'd0, i_item.first_ms};
        dl2     = now + {4'd0, i_item.second_ms};
        el_set  = now - r_settle_beg;
        el_wait = now - r_wait_dl;

        n_stop_act = r_stop_act;   n_stop_beg = r_stop_beg;
        n_stop_dur = r_stop_dur;   n_stop_dl  = r_stop_dl;
        n_start_act = r_start_act; n_start_beg = r_start_beg;
        n_start_dur = r_start_dur; n_start_dl  = r_start_dl;
        n_sleep_act = r_sleep_act; n_sleep_beg = r_sleep_beg;
        n_sleep_dur = r_sleep_dur;
        n_planned = r_planned; n_req = r_req; n_req_wake = r_req_wake;
        n_sd_on = r_sd_on; n_phase = r_phase; n_wait_dl = r_wait_dl;
        n_settle_beg = r_settle_beg; n_resume = r_resume;

        o_res     = '0;
        st        = ST_APPLIED;
        do_accept = 1'b0;
        acc_w     = r_req_wake;
        se = 1'b0; te = 1'b0; de = 1'b0; sl = 1'b0;

        // plan kind before the update
        if (r_sleep_act || r_req || r_sd_on) begin
            pk = PK_SLEEP;
        end else if (r_stop_act || r_start_act) begin
            pk = PK_RADIO;
        end else begin
            pk = PK_NONE;
        end

        // wake minutes of a sleep command
        ws   = ST_APPLIED;
        wake = 12'd0;
        pm   = (i_cfg.preset_min > i_cfg.max_minutes) ? i_cfg.max_minutes
                                                      : i_cfg.preset_min;
        if (i_item.wake_from_preset) begin
            if (i_cfg.wake_en) begin
                if (pm == 12'd0) begin
                    ws = ST_WAKE_NEED;
                end
                wake = pm;
            end
        end else if (m2 > {4'd0, i_cfg.max_minutes}) begin
            ws = ST_INVALID;
        end else begin
            wake = m2[11:0];
        end

        if (r_phase == PH_HALT) begin
            st = ST_SHUTDOWN;
        end else begin
            case (i_item.command)
                CMD_TICK: begin
                    if (r_phase != PH_NONE) begin
                        // shutdown sequence step
                        case (r_phase)
                            PH_WAIT: begin
                                if (stopped || !el_wait[31]) begin
                                    n_phase = PH_FLUSH;
                                end
                            end
                            PH_FLUSH: begin
                                o_res.p_resume = r_resume;
                                n_phase = PH_DSPOFF;
                            end
                            PH_DSPOFF: begin
                                o_res.p_dsp_off = 1'b1;
                                n_settle_beg = now;
                                n_phase = PH_SETTLE;
                            end
                            PH_SETTLE: begin
                                if (el_set >= {16'd0, i_cfg.settle_ms}) begin
                                    n_phase = PH_ENTER;
                                end
                            end
                            PH_ENTER: begin
                                o_res.p_enter = 1'b1;
                                n_phase = PH_HALT;
                            end
                            default: begin
                            end
                        endcase
                    end else if (r_req && !r_sd_on) begin
                        do_accept = 1'b1;
                    end else begin
                        se = r_stop_act && ((now - r_stop_beg) >= {4'd0, r_stop_dur});
                        te = r_start_act && ((now - r_start_beg) >= {4'd0, r_start_dur});
                        de = r_sleep_act && ((now - r_sleep_beg) >= {4'd0, r_sleep_dur});
                        if (se) begin
                            n_stop_act = 1'b0; n_stop_beg = '0; n_stop_dur = '0;
                        end
                        if (te) begin
                            n_start_act = 1'b0; n_start_beg = '0; n_start_dur = '0;
                        end
                        // both lapse: only the later deadline acts
                        if (se && te) begin
                            sl = later_than(r_start_dl, r_stop_dl);
                            se = !sl;
                            te = sl;
                        end
                        if (de) begin
                            n_sleep_act = 1'b0; n_sleep_beg = '0; n_sleep_dur = '0;
                            n_req = 1'b1;
                            n_req_wake = r_planned;
                            acc_w = r_planned;
                            do_accept = !r_sd_on;
                        end else if (se) begin
                            o_res.p_stop = !stopped;
                        end else if (te) begin
                            o_res.p_play = stopped;
                        end
                    end
                end
                CMD_PLAN: begin
                    if (m1 > {4'd0, i_cfg.max_minutes} || m2 > {4'd0, i_cfg.max_minutes}) begin
                        st = ST_INVALID;
                    end else if (m1 == 16'd0 && m2 == 16'd0) begin
                        st = ST_EMPTY;
                    end else if (m1 != 16'd0 && m2 != 16'd0 && m2 <= m1) begin
                        st = ST_ORDER;
                    end else if (pk == PK_SLEEP) begin
                        st = (r_sd_on || r_req) ? ST_SHUTDOWN : ST_SLEEP_CONF;
                    end else begin
                        n_stop_act  = (m1 != 16'd0);
                        n_stop_beg  = (m1 != 16'd0) ? now : 32'd0;
                        n_stop_dur  = i_item.first_ms;
                        n_stop_dl   = dl1;
                        n_start_act = (m2 != 16'd0);
                        n_start_beg = (m2 != 16'd0) ? now : 32'd0;
                        n_start_dur = i_item.second_ms;
                        n_start_dl  = dl2;
                    end
                end
                CMD_STOP, CMD_START: begin
                    if (m1 > {4'd0, i_cfg.max_minutes}) begin
                        st = ST_INVALID;
                    end else if (m1 == 16'd0) begin
                        if (i_item.command == CMD_STOP) begin
                            n_stop_act = 1'b0; n_stop_beg = '0; n_stop_dur = '0;
                        end else begin
                            n_start_act = 1'b0; n_start_beg = '0; n_start_dur = '0;
                        end
                        st = ST_CANCELLED;
                    end else if (pk == PK_SLEEP) begin
                        st = (r_sd_on || r_req) ? ST_SHUTDOWN : ST_SLEEP_CONF;
                    end else if (i_item.command == CMD_STOP) begin
                        if (r_start_act && !later_than(r_start_dl, dl1)) begin
                            st = ST_ORDER;
                        end else begin
                            n_stop_act = 1'b1; n_stop_beg = now;
                            n_stop_dur = i_item.first_ms; n_stop_dl = dl1;
                        end
                    end else begin
                        if (r_stop_act && !later_than(dl1, r_stop_dl)) begin
                            st = ST_ORDER;
                        end else begin
                            n_start_act = 1'b1; n_start_beg = now;
                            n_start_dur = i_item.first_ms; n_start_dl = dl1;
                        end
                    end
                end
                CMD_CANCEL_STOP, CMD_CANCEL_START, CMD_CANCEL_PLAN: begin
                    if (i_item.command != CMD_CANCEL_START) begin
                        n_stop_act = 1'b0; n_stop_beg = '0; n_stop_dur = '0;
                    end
                    if (i_item.command != CMD_CANCEL_STOP) begin
                        n_start_act = 1'b0; n_start_beg = '0; n_start_dur = '0;
                    end
                    st = ST_CANCELLED;
                end
                CMD_SLEEP: begin
                    if (m1 > {4'd0, i_cfg.max_minutes}) begin
                        st = ST_INVALID;
                    end else if (m1 == 16'd0) begin
                        st = ST_EMPTY;
                    end else if (ws != ST_APPLIED) begin
                        st = ws;
                    end else if (pk == PK_RADIO) begin
                        st = ST_RADIO_CONF;
                    end else if (r_sd_on || r_req) begin
                        st = ST_SHUTDOWN;
                    end else begin
                        n_sleep_act = 1'b1; n_sleep_beg = now;
                        n_sleep_dur = i_item.first_ms;
                        n_planned = wake;
                    end
                end
                CMD_CANCEL_SLEEP: begin
                    if (r_sd_on) begin
                        st = ST_SHUTDOWN;
                    end else begin
                        n_sleep_act = 1'b0; n_sleep_beg = '0; n_sleep_dur = '0;
                        n_planned = '0; n_req = 1'b0; n_req_wake = '0;
                        st = ST_CANCELLED;
                    end
                end
                CMD_SLEEP_NOW: begin
                    if (ws != ST_APPLIED) begin
                        st = ws;
                    end else if (r_sd_on || r_req) begin
                        st = ST_SHUTDOWN;
                    end else begin
                        n_stop_act = 1'b0;  n_stop_beg = '0;  n_stop_dur = '0;
                        n_start_act = 1'b0; n_start_beg = '0; n_start_dur = '0;
                        n_sleep_act = 1'b0; n_sleep_beg = '0; n_sleep_dur = '0;
                        n_planned = wake; n_req = 1'b1; n_req_wake = wake;
                    end
                end
                CMD_QUERY: begin
                end
                default: begin
                    st = ST_INVALID;
                end
            endcase
        end

        // shutdown acceptance of a pending request
        if (do_accept) begin
            n_stop_act = 1'b0;  n_stop_beg = '0;  n_stop_dur = '0;
            n_start_act = 1'b0; n_start_beg = '0; n_start_dur = '0;
            n_sleep_act = 1'b0; n_sleep_beg = '0; n_sleep_dur = '0;
            n_planned = acc_w;
            n_req = 1'b0; n_req_wake = '0;
            n_sd_on = 1'b1;
            n_wait_dl = now + {16'd0, i_cfg.stop_wait_ms};
            n_resume = !stopped;
            o_res.p_stop = !stopped;
            n_phase = stopped ? PH_FLUSH : PH_WAIT;
        end

        // result after the update
        o_res.status = st;
        if (n_sleep_act || n_req || n_sd_on) begin
            o_res.plan_kind = PK_SLEEP;
        end else if (n_stop_act || n_start_act) begin
            o_res.plan_kind = PK_RADIO;
        end else begin
            o_res.plan_kind = PK_NONE;
        end
        o_res.stop_rem_ms  = rem_ms(n_stop_act, n_stop_beg, n_stop_dur, now);
        o_res.start_rem_ms = rem_ms(n_start_act, n_start_beg, n_start_dur, now);
        o_res.sleep_rem_ms = rem_ms(n_sleep_act, n_sleep_beg, n_sleep_dur, now);
        o_res.wake_after   = n_req ? n_req_wake : n_planned;
        o_res.busy         = n_sd_on || n_req;
    end

    // state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stop_act <= 1'b0;  r_stop_beg <= '0;  r_stop_dur <= '0;  r_stop_dl <= '0;
            r_start_act <= 1'b0; r_start_beg <= '0; r_start_dur <= '0; r_start_dl <= '0;
            r_sleep_act <= 1'b0; r_sleep_beg <= '0; r_sleep_dur <= '0;
            r_planned <= '0; r_req <= 1'b0; r_req_wake <= '0;
            r_sd_on <= 1'b0; r_phase <= PH_NONE; r_wait_dl <= '0;
            r_settle_beg <= '0; r_resume <= 1'b0;
        end else if (i_advance) begin
            r_stop_act <= n_stop_act;   r_stop_beg <= n_stop_beg;
            r_stop_dur <= n_stop_dur;   r_stop_dl  <= n_stop_dl;
            r_start_act <= n_start_act; r_start_beg <= n_start_beg;
            r_start_dur <= n_start_dur; r_start_dl  <= n_start_dl;
            r_sleep_act <= n_sleep_act; r_sleep_beg <= n_sleep_beg;
            r_sleep_dur <= n_sleep_dur;
            r_planned <= n_planned; r_req <= n_req; r_req_wake <= n_req_wake;
            r_sd_on <= n_sd_on; r_phase <= n_phase; r_wait_dl <= n_wait_dl;
            r_settle_beg <= n_settle_beg; r_resume <= n_resume;
        end
    end

    // once halted the block stays halted
    a_halt_sticky: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_HALT |=> r_phase == PH_HALT)
        else $error("left halted phase");

    // shutdown running and a phase in progress go together
    a_sd_phase: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sd_on == (r_phase != PH_NONE))
        else $error("shutdown flag and phase disagree");

    // sleep entry is followed by the halted phase
    a_enter_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_advance && o_res.p_enter |=> r_phase == PH_HALT)
        else $error("sleep entry without halt");

    // radio countdowns are cleared while a sleep plan holds
    a_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sleep_act |-> !(r_stop_act || r_start_act))
        else $error("radio and sleep countdowns both armed");

endmodule

// ===== sv/radio_and_sleep_countdown_timers_core.sv =====
// ---------------------------------------------------------------------------
// radio_and_sleep_countdown_timers_core
// Radio stop/start and deep sleep countdowns with a shutdown sequencer.
// ---------------------------------------------------------------------------
// channel   direction  handshake          payload
// s_axis    in         tvalid / tready    command word, 70 bits in 72
// m_axis    out        tvalid / tready    result word, 78 bits in 80
// cfg       in         write enable only  index 3 bits, data 16 bits
//
// Three register stages: input, state update result, output after the
// seconds conversion. One word is taken per cycle while the output is
// not stalled; the timer state is updated as a word moves on to the
// update result stage. Reset clears all timers. A stalled output holds its
// word while the earlier stages keep filling until all are full.
// ---------------------------------------------------------------------------
module radio_and_sleep_countdown_timers_core
    import rsct_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    // command, now_ms, first_minutes, second_minutes, wake_from_preset,
    // player_stopped
    input  logic [71:0] s_axis_tdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // status, plan_kind, stop_remaining_seconds, start_remaining_seconds,
    // sleep_remaining_seconds, wake_after, shutdown_busy,
    // issue_player_stop, issue_player_play, mark_resume, display_off,
    // enter_sleep
    output logic [79:0] m_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_idx,
    input  logic [15:0] i_cfg_wdata
);

    t_cfg  r_cfg;
    t_item r_a, n_a;
    logic  r_a_valid;
    t_res  w_res;
    t_res  r_b;
    logic  r_b_valid;
    logic  [79:0] r_out;
    logic  r_out_valid;
    logic  w_mv_b, w_mv_a, w_take;
    logic  [SEC_W-1:0] w_stop_s, w_start_s, w_sleep_s;

    assign w_mv_b = r_b_valid && (!r_out_valid || m_axis_tready);
    assign w_mv_a = r_a_valid && (!r_b_valid || w_mv_b);
    assign s_axis_tready = !r_a_valid || w_mv_a;
    assign w_take = s_axis_tvalid && s_axis_tready;

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.max_minutes  <= 12'd1499;
            r_cfg.wake_en      <= 1'b0;
            r_cfg.preset_min   <= 12'd0;
            r_cfg.stop_wait_ms <= 16'd2500;
            r_cfg.settle_ms    <= 16'd50;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_MAX_MIN:   r_cfg.max_minutes  <= i_cfg_wdata[11:0];
                CFG_WAKE_EN:   r_cfg.wake_en      <= i_cfg_wdata[0];
                CFG_WAKE_MIN:  r_cfg.preset_min   <= i_cfg_wdata[11:0];
                CFG_STOP_WAIT: r_cfg.stop_wait_ms <= i_cfg_wdata;
                CFG_SETTLE:    r_cfg.settle_ms    <= i_cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    // input word unpack and minute to millisecond products
    always_comb begin
        n_a.command          = t_cmd'(s_axis_tdata[3:0]);
        n_a.now_ms           = s_axis_tdata[35:4];
        n_a.first_minutes    = s_axis_tdata[51:36];
        n_a.second_minutes   = s_axis_tdata[67:52];
        n_a.wake_from_preset = s_axis_tdata[68];
        n_a.player_stopped   = s_axis_tdata[69];
        n_a.first_ms  = {16'd0, s_axis_tdata[47:36]} * MS_PER_MIN;
        n_a.second_ms = {16'd0, s_axis_tdata[63:52]} * MS_PER_MIN;
    end

    // input stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_a_valid <= w_take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_take) begin
            r_a <= n_a;
        end
    end

    rsct_update u_update (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (w_mv_a),
        .i_item    (r_a),
        .i_cfg     (r_cfg),
        .o_res     (w_res)
    );

    // update result stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_b_valid <= 1'b0;
        end else if (!r_b_valid || w_mv_b) begin
            r_b_valid <= w_mv_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv_a) begin
            r_b <= w_res;
        end
    end

    rsct_div1000 u_div_stop  (.i_ms(r_b.stop_rem_ms),  .o_sec(w_stop_s));
    rsct_div1000 u_div_start (.i_ms(r_b.start_rem_ms), .o_sec(w_start_s));
    rsct_div1000 u_div_sleep (.i_ms(r_b.sleep_rem_ms), .o_sec(w_sleep_s));

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (!r_out_valid || m_axis_tready) begin
            r_out_valid <= w_mv_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mv_b) begin
            r_out <= {2'b00, r_b.p_enter, r_b.p_dsp_off, r_b.p_resume, r_b.p_play,
                      r_b.p_stop, r_b.busy, r_b.wake_after, w_sleep_s, w_start_s,
                      w_stop_s, r_b.plan_kind, r_b.status};
        end
    end

    assign m_axis_tdata  = r_out;
    assign m_axis_tvalid = r_out_valid;

endmodule

// ===== dv/tb_radio_and_sleep_countdown_timers_core.sv =====
// ---------------------------------------------------------------------------
// tb_radio_and_sleep_countdown_timers_core
// Self-checking testbench for the radio and sleep countdown timers.
// A scoreboard class keeps its own copy of the timer state, predicts one
// result word per command word and checks the output stream in order.
// Directed words come first, then random phases under several register
// settings and idle patterns. The run ends with one full shutdown sequence.
// ---------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_radio_and_sleep_countdown_timers_core;
    import rsct_pkg::*;

    // command word layout, lowest field last
    typedef struct packed {
        logic        player_stopped;
        logic        wake_from_preset;
        logic [15:0] second_minutes;
        logic [15:0] first_minutes;
        logic [31:0] now_ms;
        logic [3:0]  command;
    } cmd_word_t;

    // result word layout, lowest field last
    typedef struct packed {
        logic        enter_sleep;
        logic        display_off;
        logic        mark_resume;
        logic        player_play;
        logic        player_stop;
        logic        busy;
        logic [11:0] wake_after;
        logic [17:0] sleep_secs;
        logic [17:0] start_secs;
        logic [17:0] stop_secs;
        logic [1:0]  plan_kind;
        logic [3:0]  status;
    } res_word_t;

    localparam logic [31:0] MS_MIN = 32'd60000;
    localparam logic [31:0] SIGN   = 32'h8000_0000;

    // -----------------------------------------------------------------------
    // scoreboard: timer state predictor and expected result store
    // -----------------------------------------------------------------------
    class timer_scoreboard;
        logic [11:0] max_min;
        logic        wake_en;
        logic [11:0] wake_min;
        logic [15:0] stop_wait;
        logic [15:0] settle;

        logic        stop_on, start_on, sleep_on;
        logic [31:0] stop_t0, start_t0, sleep_t0;
        logic [11:0] stop_m, start_m, sleep_m;
        logic [11:0] planned_wake, req_wake, wake_snap;
        logic        req_pending, sd_on, resume_want;
        logic [2:0]  phase;
        logic [31:0] wait_dl, settle_t0;
        logic        p_stop, p_play, p_resume, p_dsp, p_enter;

        res_word_t   expected_q[$];
        int          errors;
        int          words_checked;
        int          status_seen[16];

        function new();
            max_min = 12'd1499; wake_en = 0; wake_min = 0;
            stop_wait = 16'd2500; settle = 16'd50;
            clear_all();
            req_pending = 0; req_wake = 0; sd_on = 0; phase = PH_NONE;
            wait_dl = 0; settle_t0 = 0; resume_want = 0; wake_snap = 0;
            errors = 0; words_checked = 0;
            foreach (status_seen[i]) status_seen[i] = 0;
        endfunction

        function void clear_stop();
            stop_on = 0; stop_t0 = 0; stop_m = 0;
        endfunction

        function void clear_start();
            start_on = 0; start_t0 = 0; start_m = 0;
        endfunction

        function void clear_sleep();
            sleep_on = 0; sleep_t0 = 0; sleep_m = 0;
        endfunction

        function void clear_all();
            clear_stop(); clear_start(); clear_sleep();
            planned_wake = 0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [15:0] val);
            case (idx)
                CFG_MAX_MIN:   max_min = val[11:0];
                CFG_WAKE_EN:   wake_en = val[0];
                CFG_WAKE_MIN:  wake_min = val[11:0];
                CFG_STOP_WAIT: stop_wait = val;
                CFG_SETTLE:    settle = val;
                default: ;
            endcase
        endfunction

        function logic [17:0] secs_left(logic on, logic [31:0] t0, logic [11:0] m,
                                        logic [31:0] now);
            logic [31:0] dur, el;
            dur = 32'(m) * MS_MIN;
            el = now - t0;
            if (!on || dur == 0 || el >= dur) return 0;
            return 18'((dur - el + 32'd999) / 32'd1000);
        endfunction

        function logic lapsed(logic on, logic [31:0] t0, logic [11:0] m, logic [31:0] now);
            return on && ((now - t0) >= 32'(m) * MS_MIN);
        endfunction

        function logic later(logic [31:0] a, logic [31:0] b);
            logic [31:0] d;
            d = a - b;
            return d != 0 && d < SIGN;
        endfunction

        function logic [1:0] plan_now();
            if (sleep_on || req_pending || sd_on) return PK_SLEEP;
            if (stop_on || start_on) return PK_RADIO;
            return PK_NONE;
        endfunction

        // true when a tick at this time would start or advance the shutdown sequence
        function logic tick_shuts_down(logic [31:0] now);
            return phase != PH_NONE || req_pending || lapsed(sleep_on, sleep_t0, sleep_m, now);
        endfunction

        function logic [3:0] resolve_wake(logic fp, logic [15:0] raw, output logic [11:0] w);
            logic [11:0] m;
            w = 0;
            if (fp) begin
                if (!wake_en) return ST_APPLIED;
                m = (wake_min > max_min) ? max_min : wake_min;
                if (m == 0) return ST_WAKE_NEED;
                w = m;
                return ST_APPLIED;
            end
            if (raw > 16'(max_min)) return ST_INVALID;
            w = raw[11:0];
            return ST_APPLIED;
        endfunction

        function void accept_request(logic [31:0] now, logic stopped);
            logic [11:0] w;
            w = req_wake;
            clear_all();
            planned_wake = w;
            req_pending = 0; req_wake = 0; sd_on = 1;
            wait_dl = now + 32'(stop_wait);
            resume_want = !stopped;
            wake_snap = w;
            if (!stopped) begin
                p_stop = 1; phase = PH_WAIT;
            end else begin
                phase = PH_FLUSH;
            end
        endfunction

        function void advance_shutdown(logic [31:0] now, logic stopped);
            case (phase)
                PH_WAIT:   if (stopped || (now - wait_dl) < SIGN) phase = PH_FLUSH;
                PH_FLUSH: begin
                    p_resume = resume_want; phase = PH_DSPOFF;
                end
                PH_DSPOFF: begin
                    p_dsp = 1; settle_t0 = now; phase = PH_SETTLE;
                end
                PH_SETTLE: if ((now - settle_t0) >= 32'(settle)) phase = PH_ENTER;
                PH_ENTER: begin
                    p_enter = 1; phase = PH_HALT;
                end
                default: ;
            endcase
        endfunction

        function void do_tick(logic [31:0] now, logic stopped);
            logic se, te, de, start_later;
            if (phase != PH_NONE) begin
                advance_shutdown(now, stopped);
                return;
            end
            if (req_pending && !sd_on) begin
                accept_request(now, stopped);
                return;
            end
            se = lapsed(stop_on, stop_t0, stop_m, now);
            te = lapsed(start_on, start_t0, start_m, now);
            de = lapsed(sleep_on, sleep_t0, sleep_m, now);
            // both radio countdowns lapsed: the later deadline wins, stop on a tie
            if (se && te) begin
                start_later = later(start_t0 + 32'(start_m) * MS_MIN,
                                    stop_t0 + 32'(stop_m) * MS_MIN);
                se = !start_later;
                te = start_later;
            end
            if (lapsed(stop_on, stop_t0, stop_m, now)) clear_stop();
            if (lapsed(start_on, start_t0, start_m, now)) clear_start();
            if (de) begin
                clear_sleep();
                req_pending = 1;
                req_wake = planned_wake;
                if (!sd_on) accept_request(now, stopped);
                return;
            end
            if (se) begin
                if (!stopped) p_stop = 1;
            end else if (te) begin
                if (stopped) p_play = 1;
            end
        endfunction

        function logic [3:0] arm_one(logic is_stop, logic [15:0] m, logic [31:0] now);
            logic [31:0] dl;
            dl = now + 32'(m) * MS_MIN;
            if (m > 16'(max_min)) return ST_INVALID;
            if (m == 0) begin
                if (is_stop) clear_stop();
                else clear_start();
                return ST_CANCELLED;
            end
            if (plan_now() == PK_SLEEP) return (sd_on || req_pending) ? ST_SHUTDOWN
                                                                       : ST_SLEEP_CONF;
            if (is_stop) begin
                if (start_on && !later(start_t0 + 32'(start_m) * MS_MIN, dl)) return ST_ORDER;
                stop_on = 1; stop_t0 = now; stop_m = m[11:0];
            end else begin
                if (stop_on && !later(dl, stop_t0 + 32'(stop_m) * MS_MIN)) return ST_ORDER;
                start_on = 1; start_t0 = now; start_m = m[11:0];
            end
            return ST_APPLIED;
        endfunction

        // accepted command word: update state and queue the expected result
        function void note_command(cmd_word_t c);
            logic [3:0]  st;
            logic [11:0] w;
            logic [15:0] m1, m2;
            res_word_t   r;
            m1 = c.first_minutes;
            m2 = c.second_minutes;
            st = ST_APPLIED;
            p_stop = 0; p_play = 0; p_resume = 0; p_dsp = 0; p_enter = 0;
            if (phase >= PH_HALT) begin
                st = ST_SHUTDOWN;
            end else begin
                case (c.command)
                    CMD_TICK: do_tick(c.now_ms, c.player_stopped);
                    CMD_PLAN: begin
                        if (m1 > 16'(max_min) || m2 > 16'(max_min)) st = ST_INVALID;
                        else if (m1 == 0 && m2 == 0) st = ST_EMPTY;
                        else if (m1 > 0 && m2 > 0 && m2 <= m1) st = ST_ORDER;
                        else if (plan_now() == PK_SLEEP)
                            st = (sd_on || req_pending) ? ST_SHUTDOWN : ST_SLEEP_CONF;
                        else begin
                            stop_on = (m1 != 0); stop_t0 = m1 ? c.now_ms : 0;
                            stop_m = m1[11:0];
                            start_on = (m2 != 0); start_t0 = m2 ? c.now_ms : 0;
                            start_m = m2[11:0];
                        end
                    end
                    CMD_STOP:  st = arm_one(1, m1, c.now_ms);
                    CMD_START: st = arm_one(0, m1, c.now_ms);
                    CMD_CANCEL_STOP, CMD_CANCEL_START, CMD_CANCEL_PLAN: begin
                        if (c.command != CMD_CANCEL_START) clear_stop();
                        if (c.command != CMD_CANCEL_STOP) clear_start();
                        st = ST_CANCELLED;
                    end
                    CMD_SLEEP: begin
                        if (m1 > 16'(max_min)) st = ST_INVALID;
                        else if (m1 == 0) st = ST_EMPTY;
                        else begin
                            st = resolve_wake(c.wake_from_preset, m2, w);
                            if (st == ST_APPLIED) begin
                                if (plan_now() == PK_RADIO) st = ST_RADIO_CONF;
                                else if (sd_on || req_pending) st = ST_SHUTDOWN;
                                else begin
                                    sleep_on = 1; sleep_t0 = c.now_ms; sleep_m = m1[11:0];
                                    planned_wake = w;
                                end
                            end
                        end
                    end
                    CMD_CANCEL_SLEEP: begin
                        if (sd_on) st = ST_SHUTDOWN;
                        else begin
                            clear_sleep();
                            planned_wake = 0; req_pending = 0; req_wake = 0;
                            st = ST_CANCELLED;
                        end
                    end
                    CMD_SLEEP_NOW: begin
                        st = resolve_wake(c.wake_from_preset, m2, w);
                        if (st == ST_APPLIED) begin
                            if (sd_on || req_pending) st = ST_SHUTDOWN;
                            else begin
                                clear_all();
                                planned_wake = w; req_pending = 1; req_wake = w;
                            end
                        end
                    end
                    CMD_QUERY: ;
                    default: st = ST_INVALID;
                endcase
            end
            r.status      = st;
            r.plan_kind   = plan_now();
            r.stop_secs   = secs_left(stop_on, stop_t0, stop_m, c.now_ms);
            r.start_secs  = secs_left(start_on, start_t0, start_m, c.now_ms);
            r.sleep_secs  = secs_left(sleep_on, sleep_t0, sleep_m, c.now_ms);
            r.wake_after  = req_pending ? req_wake : planned_wake;
            r.busy        = sd_on || req_pending;
            r.player_stop = p_stop;
            r.player_play = p_play;
            r.mark_resume = p_resume;
            r.display_off = p_dsp;
            r.enter_sleep = p_enter;
            status_seen[st] = status_seen[st] + 1;
            expected_q.push_back(r);
        endfunction

        task report(string msg);
            $display("MISMATCH at %0t: %s", $realtime, msg);
            errors = errors + 1;
        endtask

        // accepted result word: compare field by field with the oldest expectation
        task check_result(res_word_t got);
            res_word_t e;
            if (expected_q.size() == 0) begin
                report($sformatf("unexpected result word %h", got));
                return;
            end
            e = expected_q.pop_front();
            words_checked = words_checked + 1;
            if (got.status !== e.status)
                report($sformatf("status %0d, want %0d", got.status, e.status));
            if (got.plan_kind !== e.plan_kind)
                report($sformatf("plan_kind %0d, want %0d", got.plan_kind, e.plan_kind));
            if (got.stop_secs !== e.stop_secs)
                report($sformatf("stop secs %0d, want %0d", got.stop_secs, e.stop_secs));
            if (got.start_secs !== e.start_secs)
                report($sformatf("start secs %0d, want %0d", got.start_secs, e.start_secs));
            if (got.sleep_secs !== e.sleep_secs)
                report($sformatf("sleep secs %0d, want %0d", got.sleep_secs, e.sleep_secs));
            if (got.wake_after !== e.wake_after)
                report($sformatf("wake_after %0d, want %0d", got.wake_after, e.wake_after));
            if (got.busy !== e.busy)
                report($sformatf("busy %b, want %b", got.busy, e.busy));
            if (got.player_stop !== e.player_stop)
                report($sformatf("player stop %b, want %b", got.player_stop, e.player_stop));
            if (got.player_play !== e.player_play)
                report($sformatf("player play %b, want %b", got.player_play, e.player_play));
            if (got.mark_resume !== e.mark_resume)
                report($sformatf("mark_resume %b, want %b", got.mark_resume, e.mark_resume));
            if (got.display_off !== e.display_off)
                report($sformatf("display_off %b, want %b", got.display_off, e.display_off));
            if (got.enter_sleep !== e.enter_sleep)
                report($sformatf("enter_sleep %b, want %b", got.enter_sleep, e.enter_sleep));
        endtask
    endclass

    // -----------------------------------------------------------------------
    // clock, dut and shared controls
    // -----------------------------------------------------------------------
    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic [71:0] s_axis_tdata = '0;
    logic        s_axis_tvalid = 0;
    logic        s_axis_tready;
    logic [79:0] m_axis_tdata;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 0;
    logic        i_cfg_we = 0;
    logic [2:0]  i_cfg_idx = '0;
    logic [15:0] i_cfg_wdata = '0;

    timer_scoreboard timers_sb;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    bit          hold_request = 0;
    logic [31:0] clock_ms = 32'hFFF0_0000;
    int          words_sent = 0;

    always #5 i_clk = ~i_clk;

    radio_and_sleep_countdown_timers_core dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .s_axis_tdata (s_axis_tdata),
        .s_axis_tvalid(s_axis_tvalid),
        .s_axis_tready(s_axis_tready),
        .m_axis_tdata (m_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid),
        .m_axis_tready(m_axis_tready),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_wdata  (i_cfg_wdata)
    );

    // result side: random stalls plus the long hold-off, counted here
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && m_axis_tvalid && m_axis_tready)
                timers_sb.check_result(res_word_t'(m_axis_tdata[77:0]));
            if (hold_request) begin
                hold_left = 400;
                hold_request = 0;
            end
            if (hold_left > 0) begin
                hold_left = hold_left - 1;
                m_axis_tready <= 0;
            end else begin
                m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // run limit
    initial begin
        #8ms;
        $display("timeout with %0d results outstanding", timers_sb.expected_q.size());
        $display("radio_and_sleep_countdown_timers_core regression: fail");
        $finish;
    end

    // -----------------------------------------------------------------------
    // drivers
    // -----------------------------------------------------------------------
    task send_word(cmd_word_t c);
        if ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 0;
            do @(posedge i_clk); while ($urandom_range(99) < send_idle_pct);
        end
        s_axis_tdata  <= {2'b00, c};
        s_axis_tvalid <= 1;
        do @(posedge i_clk); while (!s_axis_tready);
        timers_sb.note_command(c);
        words_sent = words_sent + 1;
    endtask

    task send_cmd(logic [3:0] cmd, logic [31:0] dt, logic [15:0] m1, logic [15:0] m2,
                  logic fp, logic stopped);
        cmd_word_t c;
        clock_ms = clock_ms + dt;
        c.command = cmd; c.now_ms = clock_ms;
        c.first_minutes = m1; c.second_minutes = m2;
        c.wake_from_preset = fp; c.player_stopped = stopped;
        send_word(c);
    endtask

    task wait_drained();
        s_axis_tvalid <= 0;
        do @(posedge i_clk); while (timers_sb.expected_q.size() != 0);
        repeat (6) @(posedge i_clk);
    endtask

    // one register write, each in its own cycle
    task write_cfg(logic [2:0] idx, logic [15:0] val);
        @(posedge i_clk);
        i_cfg_we <= 1; i_cfg_idx <= idx; i_cfg_wdata <= val;
        @(posedge i_clk);
        i_cfg_we <= 0;
        timers_sb.write_reg(idx, val);
    endtask

    function logic [15:0] pick_minutes();
        case ($urandom_range(19))
            0:       return 16'(timers_sb.max_min);
            1:       return 16'(timers_sb.max_min) + 16'd1;
            2:       return 16'($urandom);
            3:       return 16'hFFFF;
            4, 5:    return 0;
            default: return 16'($urandom_range(1, 4));
        endcase
    endfunction

    function logic [31:0] pick_step();
        case ($urandom_range(19))
            0:       return $urandom;
            1:       return 32'($urandom_range(0, 3)) * MS_MIN;
            2, 3:    return 0;
            default: return $urandom_range(0, 90000);
        endcase
    endfunction

    // random command word; unless allowed, a tick that would shut down becomes
    // a sleep cancel so the block never halts before the last phase
    task send_random(bit allow_shutdown);
        logic [3:0]  cmd;
        logic [31:0] dt;
        int          sel;
        sel = $urandom_range(99);
        if (sel < 40) cmd = CMD_TICK;
        else if (sel < 52) cmd = CMD_PLAN;
        else if (sel < 60) cmd = CMD_STOP;
        else if (sel < 68) cmd = CMD_START;
        else if (sel < 74) cmd = 4'($urandom_range(CMD_CANCEL_STOP, CMD_CANCEL_PLAN));
        else if (sel < 84) cmd = CMD_SLEEP;
        else if (sel < 88) cmd = CMD_CANCEL_SLEEP;
        else if (sel < 92) cmd = CMD_SLEEP_NOW;
        else if (sel < 96) cmd = CMD_QUERY;
        else cmd = 4'($urandom_range(11, 15));
        dt = pick_step();
        if (!allow_shutdown && cmd == CMD_TICK && timers_sb.tick_shuts_down(clock_ms + dt))
            cmd = CMD_CANCEL_SLEEP;
        send_cmd(cmd, dt, pick_minutes(), pick_minutes(), 1'($urandom), 1'($urandom));
    endtask

    // -----------------------------------------------------------------------
    // main sequence
    // -----------------------------------------------------------------------
    initial begin
        int phase_no;
        int n;
        timers_sb = new();
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed words around the reset settings
        send_cmd(CMD_QUERY, 0, 0, 0, 0, 0);
        send_cmd(4'hF, 0, 16'hFFFF, 16'hFFFF, 1, 1);
        send_cmd(CMD_PLAN, 0, 0, 0, 0, 0);
        send_cmd(CMD_PLAN, 0, 16'd1500, 16'd2, 0, 0);
        send_cmd(CMD_PLAN, 0, 16'd3, 16'd3, 0, 0);
        send_cmd(CMD_PLAN, 0, 16'd1, 16'd2, 0, 0);
        send_cmd(CMD_SLEEP, 1000, 16'd5, 16'd0, 0, 0);
        // both radio countdowns lapse together, the later start plays
        send_cmd(CMD_TICK, 3 * MS_MIN, 0, 0, 0, 1);
        send_cmd(CMD_STOP, 0, 16'd1499, 0, 0, 0);
        send_cmd(CMD_START, 0, 16'd2, 0, 0, 0);
        send_cmd(CMD_START, 0, 16'd1499, 0, 0, 0);
        send_cmd(CMD_STOP, 0, 16'd0, 0, 0, 0);
        send_cmd(CMD_CANCEL_STOP, 0, 0, 0, 0, 0);
        send_cmd(CMD_CANCEL_START, 0, 0, 0, 0, 0);
        send_cmd(CMD_STOP, 0, 16'd1, 0, 0, 0);
        send_cmd(CMD_TICK, MS_MIN, 0, 0, 0, 0);
        send_cmd(CMD_CANCEL_PLAN, 0, 0, 0, 0, 0);
        send_cmd(CMD_SLEEP, 0, 16'd0, 0, 0, 0);
        send_cmd(CMD_SLEEP, 0, 16'd2, 16'd1500, 0, 0);
        send_cmd(CMD_SLEEP, 0, 16'd2, 16'd7, 1, 0);
        send_cmd(CMD_PLAN, 0, 16'd1, 16'd2, 0, 0);
        send_cmd(CMD_STOP, 0, 16'd1, 0, 0, 0);
        send_cmd(CMD_SLEEP_NOW, 0, 0, 16'd9, 0, 0);
        send_cmd(CMD_SLEEP_NOW, 0, 0, 16'd9, 0, 0);
        send_cmd(CMD_CANCEL_SLEEP, 0, 0, 0, 0, 0);

        // random phases, each under its own register settings and idle pattern
        for (phase_no = 0; phase_no < 5; phase_no++) begin
            wait_drained();
            case (phase_no)
                0: begin
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
                1: begin
                    write_cfg(CFG_MAX_MIN, 16'd4095);
                    write_cfg(CFG_WAKE_EN, 16'd1);
                    write_cfg(CFG_WAKE_MIN, 16'd0);
                    write_cfg(CFG_STOP_WAIT, 16'd0);
                    write_cfg(CFG_SETTLE, 16'd0);
                    send_idle_pct = 79; recv_stall_pct = 0;
                end
                2: begin
                    write_cfg(CFG_MAX_MIN, 16'd1);
                    write_cfg(CFG_WAKE_MIN, 16'hFFFF);
                    write_cfg(CFG_STOP_WAIT, 16'hFFFF);
                    write_cfg(CFG_SETTLE, 16'hFFFF);
                    send_idle_pct = 0; recv_stall_pct = 79;
                end
                3: begin
                    write_cfg(CFG_MAX_MIN, 16'd7);
                    write_cfg(CFG_WAKE_EN, 16'd0);
                    write_cfg(CFG_WAKE_MIN, 16'd3);
                    send_idle_pct = 8; recv_stall_pct = 8;
                end
                default: begin
                    write_cfg(CFG_MAX_MIN, 16'd1499);
                    write_cfg(CFG_WAKE_EN, 16'd1);
                    write_cfg(CFG_WAKE_MIN, 16'd5);
                    write_cfg(CFG_STOP_WAIT, 16'd2500);
                    write_cfg(CFG_SETTLE, 16'd50);
                    send_idle_pct = 0; recv_stall_pct = 0;
                end
            endcase
            for (n = 0; n < 170; n++) begin
                // long output hold-off while words keep coming
                if (phase_no == 3 && n == 40) hold_request = 1;
                send_random(0);
            end
        end

        // last phase: let one shutdown run through to sleep entry
        if ($urandom_range(1)) begin
            send_cmd(CMD_CANCEL_SLEEP, 0, 0, 0, 0, 0);
            send_cmd(CMD_CANCEL_PLAN, 0, 0, 0, 0, 0);
            send_cmd(CMD_SLEEP, 0, 16'd1, 0, 1, 0);
            send_cmd(CMD_TICK, MS_MIN, 0, 0, 0, 0);
        end else begin
            send_cmd(CMD_SLEEP_NOW, 0, 0, 16'd12, 0, 0);
            send_cmd(CMD_TICK, 10, 0, 0, 0, 0);
        end
        n = 0;
        while (timers_sb.phase != PH_HALT && n < 400) begin
            if ($urandom_range(3) == 0) send_random(1);
            else send_cmd(CMD_TICK, $urandom_range(0, 1500), 0, 0, 0, $urandom_range(4) == 0);
            n++;
        end
        for (n = 0; n < 6; n++) send_random(1);

        wait_drained();
        $display("covered %0d command words, %0d results checked, shutdown phase %0d",
                 words_sent, timers_sb.words_checked, timers_sb.phase);
        $display("status counts applied %0d cancelled %0d invalid %0d order %0d shutdown %0d",
                 timers_sb.status_seen[ST_APPLIED], timers_sb.status_seen[ST_CANCELLED],
                 timers_sb.status_seen[ST_INVALID], timers_sb.status_seen[ST_ORDER],
                 timers_sb.status_seen[ST_SHUTDOWN]);
        if (timers_sb.errors == 0) begin
            $display("radio_and_sleep_countdown_timers_core regression: pass");
        end else begin
            $display("radio_and_sleep_countdown_timers_core regression: fail");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
sv/rsct_pkg.sv
sv/rsct_div1000.sv
sv/rsct_update.sv
sv/radio_and_sleep_countdown_timers_core.sv
dv/tb_radio_and_sleep_countdown_timers_core.sv
